@@ rtl/ple_pkg.sv @@
package ple_pkg;

    // Number of entries in the list store.
    localparam int CAPACITY = 64;

    // Entry index, live count and the fixed field widths of the streams.
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = 7;
    localparam int VW = 32;

    // Width used when positions are compared with the live count.
    localparam int MW = (CW > PW) ? CW + 1 : PW + 1;

    // Stream word layout.
    localparam int IN_DW  = 40;
    localparam int OUT_DW = 48;
    localparam int UW     = 2;

    typedef enum logic [1:0] {
        F_APPEND = 2'd0,
        F_INSERT = 2'd1,
        F_DELETE = 2'd2,
        F_LOCATE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

endpackage

@@ rtl/ple_ram.sv @@
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/positional_list_engine_unit.sv @@
// Positional list engine: keeps an ordered list of up to CAPACITY signed
// 32-bit values in a RAM with one write port and one registered read port,
// together with a live count, and serves one request word at a time. An
// append, a locate on an empty list and any request that is refused with an
// error status go straight from acceptance to the result step. Insert and
// delete move every later entry by one place, one RAM read and one RAM write
// per cycle with the read and write overlapped; an insert that lands just
// past the tail moves nothing, and a delete first reads the entry being
// removed. Locate reads the live entries in order, one per cycle, and stops
// at the first match, or after the last live entry when nothing matches. The
// slowest request is a delete at the head of a full list, bounded by the
// single read port of the entry store. The input is not ready while a
// request is being worked on and becomes ready again in the cycle after the
// result is loaded. The finished result sits in an output register, so a new
// request may be accepted while the previous result still waits to be taken;
// a further result then waits in the last step until the output register is
// free. Entries are never cleared: only live entries are ever read.
module positional_list_engine_unit
    import ple_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request words.
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // tdata, lowest bit up: position [6:0], value [38:7], zero [39].
    input  logic [IN_DW-1:0]  i_s_axis_tdata,
    // tuser: func [1:0].
    input  logic [UW-1:0]     i_s_axis_tuser,
    // Result words.
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // tdata, lowest bit up: removed_value [31:0], found_position [38:32],
    // fill_count [45:39], zero [47:46].
    output logic [OUT_DW-1:0] o_m_axis_tdata,
    // tuser: status [1:0].
    output logic [UW-1:0]     o_m_axis_tuser
);

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_DEL  = 5'b00100,
        S_LOC  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [VW-1:0]   r_val, n_val;
    logic [IW-1:0]   r_src, n_src;     // next entry to read
    logic [IW-1:0]   r_dst, n_dst;     // destination of the data now returning
    logic [IW-1:0]   r_lo, n_lo;       // insert slot
    logic [IW-1:0]   r_hi, n_hi;       // last entry to read for delete or locate
    logic            r_issue, n_issue; // reads still to be issued
    logic            r_pend, n_pend;   // read data returns this cycle
    logic            r_first, n_first; // returning data is the deleted entry

    t_status         r_res_status, n_res_status;
    logic [VW-1:0]   r_res_rem, n_res_rem;
    logic [PW-1:0]   r_res_pos, n_res_pos;

    logic            r_out_valid, n_out_valid;
    t_status         r_out_status, n_out_status;
    logic [VW-1:0]   r_out_rem, n_out_rem;
    logic [PW-1:0]   r_out_pos, n_out_pos;
    logic [PW-1:0]   r_out_fill, n_out_fill;

    // RAM port signals.
    logic            ram_we, ram_re;
    logic [IW-1:0]   ram_waddr, ram_raddr;
    logic [VW-1:0]   ram_wdata, ram_rdata;

    // Request fields.
    t_func           in_func;
    logic [PW-1:0]   in_pos;
    logic [VW-1:0]   in_val;
    logic [MW-1:0]   pos_w, cnt_w;
    logic            in_fire, list_full;

    assign in_func = t_func'(i_s_axis_tuser);
    assign in_pos  = i_s_axis_tdata[PW-1:0];
    assign in_val  = i_s_axis_tdata[PW+VW-1:PW];
    assign pos_w   = MW'(in_pos);
    assign cnt_w   = MW'(r_count);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_fire         = i_s_axis_tvalid && (r_state == S_IDLE);
    assign list_full       = (r_count == CW'(CAPACITY));

    ple_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_val        = r_val;
        n_src        = r_src;
        n_dst        = r_dst;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_issue      = r_issue;
        n_pend       = 1'b0;
        n_first      = r_first;
        n_res_status = r_res_status;
        n_res_rem    = r_res_rem;
        n_res_pos    = r_res_pos;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_rem    = r_out_rem;
        n_out_pos    = r_out_pos;
        n_out_fill   = r_out_fill;

        ram_we    = 1'b0;
        ram_waddr = r_dst;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_src;

        // The waiting result leaves when the downstream side takes it.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_val        = in_val;
                    n_res_status = ST_OK;
                    n_res_rem    = '0;
                    n_res_pos    = '0;
                    n_state      = S_DONE;
                    unique case (in_func)
                        F_APPEND: begin
                            if (list_full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[IW-1:0];
                                ram_wdata = in_val;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        F_INSERT: begin
                            if (list_full) begin
                                n_res_status = ST_FULL;
                            end else if (pos_w == '0 || pos_w > cnt_w + MW'(1)) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                // Entries from the last one down to the slot move up.
                                n_lo    = IW'(pos_w - MW'(1));
                                n_src   = IW'(cnt_w - MW'(1));
                                n_issue = (pos_w != cnt_w + MW'(1));
                                n_state = S_INS;
                            end
                        end
                        F_DELETE: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else if (pos_w == '0 || pos_w > cnt_w) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                // The first read fetches the entry being removed.
                                n_src   = IW'(pos_w - MW'(1));
                                n_hi    = IW'(cnt_w - MW'(1));
                                n_issue = 1'b1;
                                n_first = 1'b1;
                                n_state = S_DEL;
                            end
                        end
                        F_LOCATE: begin
                            if (r_count != '0) begin
                                n_src   = '0;
                                n_hi    = IW'(cnt_w - MW'(1));
                                n_issue = 1'b1;
                                n_state = S_LOC;
                            end
                        end
                    endcase
                end
            end

            S_INS: begin
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_dst;
                    ram_wdata = ram_rdata;
                end
                if (r_issue) begin
                    ram_re = 1'b1;
                    n_pend = 1'b1;
                    n_dst  = r_src + IW'(1);
                    if (r_src == r_lo) begin
                        n_issue = 1'b0;
                    end else begin
                        n_src = r_src - IW'(1);
                    end
                end else if (!r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_lo;
                    ram_wdata = r_val;
                    n_count   = r_count + CW'(1);
                    n_state   = S_DONE;
                end
            end

            S_DEL: begin
                if (r_pend) begin
                    if (r_first) begin
                        n_res_rem = ram_rdata;
                        n_first   = 1'b0;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_dst;
                        ram_wdata = ram_rdata;
                    end
                end
                if (r_issue) begin
                    ram_re = 1'b1;
                    n_pend = 1'b1;
                    n_dst  = r_src - IW'(1);
                    if (r_src == r_hi) begin
                        n_issue = 1'b0;
                    end else begin
                        n_src = r_src + IW'(1);
                    end
                end else if (!r_pend) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end

            S_LOC: begin
                if (r_pend && ram_rdata == r_val) begin
                    n_res_pos = PW'(CW'(r_dst) + CW'(1));
                    n_issue   = 1'b0;
                    n_state   = S_DONE;
                end else if (r_issue) begin
                    ram_re = 1'b1;
                    n_pend = 1'b1;
                    n_dst  = r_src;
                    if (r_src == r_hi) begin
                        n_issue = 1'b0;
                    end else begin
                        n_src = r_src + IW'(1);
                    end
                end else begin
                    // Every live entry has been compared without a match.
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_rem    = r_res_rem;
                    n_out_pos    = r_res_pos;
                    n_out_fill   = PW'(r_count);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val        <= n_val;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_res_status <= n_res_status;
        r_res_rem    <= n_res_rem;
        r_res_pos    <= n_res_pos;
        r_out_status <= n_out_status;
        r_out_rem    <= n_out_rem;
        r_out_pos    <= n_out_pos;
        r_out_fill   <= n_out_fill;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_fill, r_out_pos, r_out_rem};
    assign o_m_axis_tuser  = r_out_status;

endmodule

@@ dv/ple_list_checker.sv @@
// Watches both streams of the list engine, keeps its own copy of the list
// and compares every result word with the expectation for the oldest request
// that has not yet been answered.
module ple_list_checker
    import ple_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    // tdata, lowest bit up: position [6:0], value [38:7], zero [39].
    input  logic [IN_DW-1:0]  i_req_data,
    // tuser: func [1:0].
    input  logic [UW-1:0]     i_req_user,
    input  logic              i_rsp_valid,
    input  logic              i_rsp_ready,
    // tdata, lowest bit up: removed_value [31:0], found_position [38:32],
    // fill_count [45:39], zero [47:46].
    input  logic [OUT_DW-1:0] i_rsp_data,
    // tuser: status [1:0].
    input  logic [UW-1:0]     i_rsp_user,
    output int                o_outstanding,
    output int                o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status     status;
        logic [31:0] removed;
        logic [6:0]  found;
        logic [6:0]  fill;
    } t_list_result;

    logic [31:0]  list_store [CAPACITY];
    int unsigned  list_len;
    t_list_result awaited_results [$];
    int           mismatches;

    // Applies one request to the shadow list and returns the result word it
    // should produce.
    function automatic t_list_result apply_request(t_func op, logic [6:0] pos,
                                                   logic [31:0] val);
        t_list_result res;
        int unsigned  p;
        res        = '0;
        res.status = ST_OK;
        p          = pos;
        case (op)
            F_APPEND: begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_store[list_len] = val;
                    list_len++;
                end
            end
            F_INSERT: begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (p < 1 || p > list_len + 1) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int k = list_len; k >= p; k--)
                        list_store[k] = list_store[k-1];
                    list_store[p-1] = val;
                    list_len++;
                end
            end
            F_DELETE: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (p < 1 || p > list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    res.removed = list_store[p-1];
                    for (int k = p; k < list_len; k++)
                        list_store[k-1] = list_store[k];
                    list_len--;
                end
            end
            default: begin
                for (int k = 0; k < list_len; k++) begin
                    if (list_store[k] == val && res.found == 0)
                        res.found = 7'(k + 1);
                end
            end
        endcase
        res.fill = 7'(list_len);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (!i_rst_n) begin
            list_len = 0;
            awaited_results.delete();
        end else begin
            // A result leaving at this edge always belongs to an earlier
            // request, so the queue is popped before the new request is added.
            if (i_rsp_valid && i_rsp_ready) begin
                got.status  = t_status'(i_rsp_user[1:0]);
                got.removed = i_rsp_data[31:0];
                got.found   = i_rsp_data[38:32];
                got.fill    = i_rsp_data[45:39];
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    $display({"%0t: unexpected result word, expected none, ",
                              "got status %0d removed %h found %0d fill %0d"},
                             $time, got.status, got.removed, got.found, got.fill);
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        $display({"%0t: result mismatch, expected status %0d ",
                                  "removed %h found %0d fill %0d, got status %0d ",
                                  "removed %h found %0d fill %0d"},
                                 $time, want.status, want.removed, want.found,
                                 want.fill, got.status, got.removed, got.found,
                                 got.fill);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                awaited_results.push_back(apply_request(t_func'(i_req_user[1:0]),
                                                        i_req_data[6:0],
                                                        i_req_data[38:7]));
        end
        o_outstanding <= awaited_results.size();
        o_mismatches  <= mismatches;
    end

endmodule

@@ dv/tb_positional_list_engine_unit.sv @@
// Top of the testbench for the positional list engine. It makes the request
// words, paces both streams and gives the verdict; all prediction and
// comparison lives in the checker that sits beside the block.
module tb_positional_list_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1150;

    // Kinds of random stretch: the list is grown, shrunk or worked evenly.
    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIX    = 2;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // tdata, lowest bit up: position [6:0], value [38:7], zero [39].
    logic [IN_DW-1:0]  s_tdata = '0;
    // tuser: func [1:0].
    logic [UW-1:0]     s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // tdata, lowest bit up: removed_value [31:0], found_position [38:32],
    // fill_count [45:39], zero [47:46].
    logic [OUT_DW-1:0] m_tdata;
    // tuser: status [1:0].
    logic [UW-1:0]     m_tuser;

    int outstanding;
    int mismatches;
    int cycle_count = 0;

    // Words left in the current burst of the sender.
    int burst_left = 1;
    // The length the list should have, used only to steer positions.
    int steer_len = 0;
    logic [31:0] value_pool [16];

    positional_list_engine_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    ple_list_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (s_tvalid),
        .i_req_ready   (s_tready),
        .i_req_data    (s_tdata),
        .i_req_user    (s_tuser),
        .i_rsp_valid   (m_tvalid),
        .i_rsp_ready   (m_tready),
        .i_rsp_data    (m_tdata),
        .i_rsp_user    (m_tuser),
        .o_outstanding (outstanding),
        .o_mismatches  (mismatches)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // A hard ceiling on the run, far above the slowest correct run, so that
    // a hung handshake cannot keep the simulation going.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** positional_list_engine_unit: FAILED **");
            $finish;
        end
    end

    // The receiver switches between three behaviours: always ready, ready at
    // random, or long stalls broken by single ready cycles.
    // This way stalls land on every phase of the block's work.
    initial begin
        int mode;
        int mode_left;
        int stall_left;
        mode_left  = 0;
        stall_left = 0;
        mode       = 0;
        forever begin
            @(posedge clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(200, 1000);
            end
            mode_left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if (stall_left > 0) begin
                        m_tready <= 1'b0;
                        stall_left--;
                    end else begin
                        m_tready   <= 1'b1;
                        stall_left = $urandom_range(1, 30);
                    end
                end
            endcase
        end
    end

    // Keeps the steering length in step with what the block should hold.
    // It only shapes positions; the checker does the real prediction.
    function automatic void follow_length(t_func op, logic [6:0] pos);
        case (op)
            F_APPEND: if (steer_len < CAPACITY) steer_len++;
            F_INSERT: if (steer_len < CAPACITY && pos >= 1 && pos <= steer_len + 1)
                steer_len++;
            F_DELETE: if (steer_len > 0 && pos >= 1 && pos <= steer_len)
                steer_len--;
            default: ;
        endcase
    endfunction

    // Presents one request word and holds it until it is taken. Words go out
    // in bursts; at the end of a burst valid drops before the next word, so
    // it is never lowered and raised in the same step.
    task automatic send_request(t_func op, logic [6:0] pos, logic [31:0] val);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, val, pos};
        do @(posedge clk); while (!s_tready);
        follow_length(op, pos);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            // Now and then a long burst gives a stretch with no sender gaps.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 300)
                                                     : $urandom_range(1, 24);
        end
    endtask

    // Half of the values come from a small pool so that locates find matches
    // and duplicates appear; the rest are fully random.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, 15)];
        return $urandom();
    endfunction

    // Position for insert or delete: mostly inside the live range with the
    // ends favoured, sometimes just outside it or anywhere in the field.
    function automatic logic [6:0] pick_position(int top_pos);
        int r;
        r = $urandom_range(0, 99);
        if (top_pos < 1 || r < 6)
            return 7'($urandom_range(0, 127));
        if (r < 10)
            return (r < 8) ? 7'd0 : 7'(top_pos + 1);
        if (r < 20)
            return 7'd1;
        if (r < 30)
            return 7'(top_pos);
        return 7'($urandom_range(1, top_pos));
    endfunction

    initial begin
        int          mode;
        int          mode_left;
        int          r;
        t_func       op;
        logic [6:0]  pos;
        logic [31:0] val;

        foreach (value_pool[i])
            value_pool[i] = $urandom();
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;

        // Synchronous reset held from the start, then released once.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. On an empty list a delete reports empty whatever
        // the position, a locate finds nothing and inserts must use
        // position one.
        send_request(F_DELETE, 7'd1, 32'h0000_0000);
        send_request(F_DELETE, 7'd0, 32'h0000_0000);
        send_request(F_LOCATE, 7'd0, 32'h0000_0000);
        send_request(F_INSERT, 7'd0, 32'h1111_1111);
        send_request(F_INSERT, 7'd2, 32'h2222_2222);
        send_request(F_INSERT, 7'd1, 32'h8000_0000);
        send_request(F_APPEND, 7'd0, 32'h7FFF_FFFF);
        send_request(F_APPEND, 7'd0, 32'h0000_0000);
        send_request(F_APPEND, 7'd0, 32'hFFFF_FFFF);
        // Insert just past the tail, then at the head.
        send_request(F_INSERT, 7'd5, 32'h1234_5678);
        send_request(F_INSERT, 7'd1, 32'hA5A5_A5A5);
        send_request(F_APPEND, 7'd0, 32'hFFFF_FFFF);
        // Locates: a hit, the first of two equal entries, and a miss.
        send_request(F_LOCATE, 7'd0, 32'h7FFF_FFFF);
        send_request(F_LOCATE, 7'd0, 32'hFFFF_FFFF);
        send_request(F_LOCATE, 7'd0, 32'h5A5A_5A5A);
        // Positions outside the live range for insert and delete.
        send_request(F_INSERT, 7'd127, 32'h3333_3333);
        send_request(F_INSERT, 7'd9, 32'h4444_4444);
        send_request(F_DELETE, 7'd0, 32'h0000_0000);
        send_request(F_DELETE, 7'd8, 32'h0000_0000);
        send_request(F_DELETE, 7'd127, 32'h0000_0000);
        // Deletes at the tail, the head and the middle.
        send_request(F_DELETE, 7'd7, 32'h0000_0000);
        send_request(F_DELETE, 7'd1, 32'h0000_0000);
        send_request(F_DELETE, 7'd3, 32'h0000_0000);
        send_request(F_LOCATE, 7'd0, 32'h8000_0000);
        // The position field is ignored by an append.
        send_request(F_APPEND, 7'd127, 32'h0000_0001);

        // Random part. It opens with a growing stretch so that the list
        // fills early and the full case is met, then moves between growing,
        // shrinking and even stretches. One word in ten is plain noise.
        mode      = MODE_GROW;
        mode_left = 130;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (mode_left == 0) begin
                mode      = $urandom_range(MODE_GROW, MODE_MIX);
                mode_left = $urandom_range(40, 120);
            end
            mode_left--;
            r   = $urandom_range(0, 99);
            val = pick_value();
            pos = 7'($urandom_range(0, 127));
            if ($urandom_range(0, 9) == 0) begin
                op = t_func'($urandom_range(0, 3));
            end else begin
                case (mode)
                    MODE_GROW:
                        op = (r < 45) ? F_APPEND : (r < 85) ? F_INSERT :
                             (r < 92) ? F_DELETE : F_LOCATE;
                    MODE_SHRINK:
                        op = (r < 10) ? F_APPEND : (r < 20) ? F_INSERT :
                             (r < 75) ? F_DELETE : F_LOCATE;
                    default:
                        op = t_func'(r % 4);
                endcase
                if (op == F_INSERT)
                    pos = pick_position(steer_len + 1);
                else if (op == F_DELETE)
                    pos = pick_position(steer_len);
            end
            send_request(op, pos, val);
        end
        s_tvalid <= 1'b0;

        // The checker's count is registered, so the bench waits for it to catch up
        // before looking at it, then until every result has been taken, then long
        // enough for a stray extra result to show up.
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (2 * CAPACITY + 16) @(posedge clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("** positional_list_engine_unit: PASSED **");
        end else begin
            $display("** positional_list_engine_unit: FAILED **");
        end
        $finish;
    end

endmodule
